// ===== rtl/adc_scan_pkg.sv =====
`default_nettype none

package adc_scan_pkg;

    // Fixed by the field widths of the ports
    localparam int NUM_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 10;
    localparam int CH_BITS      = $clog2(NUM_CHANNELS);
    localparam int SLOT_BITS    = 4;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DAT_BITS = 8;

    localparam logic [SLOT_BITS-1:0] NO_SLOT = SLOT_BITS'(NUM_CHANNELS);

    typedef enum logic [1:0] {
        CMD_CONV_DONE   = 2'd0,
        CMD_READ_SLOT   = 2'd1,
        CMD_RESTART     = 2'd2,
        CMD_READ_LATEST = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SCAN_MODE      = 2'd0,
        REG_CHANNEL_MASK   = 2'd1,
        REG_SINGLE_CHANNEL = 2'd2,
        REG_UNUSED         = 2'd3
    } cfg_reg_t;

    typedef logic [NUM_CHANNELS-1:0] ch_mask_t;
    typedef logic [CH_BITS-1:0]      ch_t;
    typedef logic [SAMPLE_BITS-1:0]  sample_t;

endpackage

`default_nettype wire

// ===== rtl/adc_channel_scan_sequencer.sv =====
`default_nettype none
// ADC channel scan sequencer.
// Input channel (in_valid / in_stall): one command word per transfer
// (cmd, sample, read_channel). Conversion-done words carry the converter
// result; read words fetch a slot or the latest single-mode sample.
// Output channel (out_valid / out_stall): one result word per command word
// (mux_channel, written_slot, read_value, ready_flag), in command order.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 scan
// mode, 1 channel mask, 2 single channel; other indexes are dropped. Always
// ready; write only while no command word is in flight.
// Timing: a command word is captured in the input register at the accepting
// edge, evaluated there against the sequencer state and registered into the
// output register once that register can advance; a stalled output holds it
// in the input register. One word per cycle sustained while out_stall stays
// low; the single evaluation stage sets the figure.
// Stall: while out_stall holds a full output register, the input register
// holds too and in_stall rises once it is full.
// Reset: mux on channel 0, all slots and latest sample zero, ready flag low,
// single mode, mask all ones, single channel 0.
module adc_channel_scan_sequencer
(
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    // command words
    input  wire logic                                       in_valid,
    output logic                                            in_stall,
    input  wire logic [1:0]                                 cmd,
    input  wire logic [adc_scan_pkg::SAMPLE_BITS-1:0]       sample,
    input  wire logic [adc_scan_pkg::CH_BITS-1:0]           read_channel,
    // result words
    output logic                                            out_valid,
    input  wire logic                                       out_stall,
    output logic [adc_scan_pkg::CH_BITS-1:0]                mux_channel,
    output logic [adc_scan_pkg::SLOT_BITS-1:0]              written_slot,
    output logic [adc_scan_pkg::SAMPLE_BITS-1:0]            read_value,
    output logic                                            ready_flag,
    // register writes
    input  wire logic                                       cfg_valid,
    output logic                                            cfg_ready,
    input  wire logic [adc_scan_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [adc_scan_pkg::CFG_DAT_BITS-1:0]      cfg_data
);

    // Lowest set bit of a mask (0 when empty)
    function automatic adc_scan_pkg::ch_t lowest_set(input adc_scan_pkg::ch_mask_t m);
        adc_scan_pkg::ch_t r;
        r = '0;
        for (int i = adc_scan_pkg::NUM_CHANNELS - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                r = adc_scan_pkg::CH_BITS'(i);
            end
        end
        return r;
    endfunction

    // Highest set bit of a mask (0 when empty)
    function automatic adc_scan_pkg::ch_t highest_set(input adc_scan_pkg::ch_mask_t m);
        adc_scan_pkg::ch_t r;
        r = '0;
        for (int i = 0; i < adc_scan_pkg::NUM_CHANNELS; i++)
        begin
            if (m[i])
            begin
                r = adc_scan_pkg::CH_BITS'(i);
            end
        end
        return r;
    endfunction

    localparam adc_scan_pkg::ch_mask_t MASK_ONE = adc_scan_pkg::NUM_CHANNELS'(1);
    localparam adc_scan_pkg::ch_mask_t MASK_TWO = adc_scan_pkg::NUM_CHANNELS'(2);

    // Configuration registers
    logic                   scan_mode_reg;
    adc_scan_pkg::ch_mask_t channel_mask_reg;
    adc_scan_pkg::ch_t      single_channel_reg;

    // Input register
    logic                   s1_valid_reg;
    adc_scan_pkg::cmd_t     s1_cmd_reg;
    adc_scan_pkg::sample_t  s1_sample_reg;
    adc_scan_pkg::ch_t      s1_rch_reg;

    // Sequencer state
    adc_scan_pkg::ch_t      cur_channel_reg;
    adc_scan_pkg::ch_t      cur_channel_next;
    adc_scan_pkg::sample_t  store_reg [adc_scan_pkg::NUM_CHANNELS];
    adc_scan_pkg::sample_t  latest_reg;
    adc_scan_pkg::sample_t  latest_next;
    logic                   ready_reg;
    logic                   ready_next;

    // Output register
    logic                           out_valid_reg;
    adc_scan_pkg::ch_t              mux_channel_reg;
    logic [adc_scan_pkg::SLOT_BITS-1:0] written_slot_reg;
    logic [adc_scan_pkg::SLOT_BITS-1:0] written_slot_next;
    adc_scan_pkg::sample_t          read_value_reg;
    adc_scan_pkg::sample_t          read_value_next;

    // Handshake
    logic out_advance;
    logic s1_fire;
    logic in_fire;
    logic store_we;
    adc_scan_pkg::ch_t store_waddr;

    // Channel search
    adc_scan_pkg::ch_mask_t below_mask;
    adc_scan_pkg::ch_mask_t above_mask;
    adc_scan_pkg::ch_t      prev_ch;
    adc_scan_pkg::ch_t      next_ch;

    assign out_advance = !out_valid_reg || !out_stall;
    assign s1_fire     = s1_valid_reg && out_advance;
    assign in_stall    = s1_valid_reg && !out_advance;
    assign in_fire     = in_valid && !in_stall;
    assign cfg_ready   = 1'b1;

    assign out_valid    = out_valid_reg;
    assign mux_channel  = mux_channel_reg;
    assign written_slot = written_slot_reg;
    assign read_value   = read_value_reg;
    assign ready_flag   = ready_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg      <= 1'b0;
            channel_mask_reg   <= '1;
            single_channel_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (adc_scan_pkg::cfg_reg_t'(cfg_index))
                adc_scan_pkg::REG_SCAN_MODE:
                begin
                    scan_mode_reg <= cfg_data[0];
                end
                adc_scan_pkg::REG_CHANNEL_MASK:
                begin
                    channel_mask_reg <= cfg_data[adc_scan_pkg::NUM_CHANNELS-1:0];
                end
                adc_scan_pkg::REG_SINGLE_CHANNEL:
                begin
                    single_channel_reg <= cfg_data[adc_scan_pkg::CH_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (out_advance || !s1_valid_reg)
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg    <= adc_scan_pkg::cmd_t'(cmd);
            s1_sample_reg <= sample;
            s1_rch_reg    <= read_channel;
        end
    end

    // Previous masked channel below current (wrap to highest), next above (wrap to lowest)
    assign below_mask = channel_mask_reg & ((MASK_ONE << cur_channel_reg) - MASK_ONE);
    assign above_mask = channel_mask_reg & ~((MASK_TWO << cur_channel_reg) - MASK_ONE);
    assign prev_ch = (below_mask != '0) ? highest_set(below_mask) : highest_set(channel_mask_reg);
    assign next_ch = (above_mask != '0) ? lowest_set(above_mask) : lowest_set(channel_mask_reg);

    always_comb
    begin
        cur_channel_next  = cur_channel_reg;
        latest_next       = latest_reg;
        ready_next        = ready_reg;
        written_slot_next = adc_scan_pkg::NO_SLOT;
        read_value_next   = '0;
        store_we          = 1'b0;
        store_waddr       = prev_ch;
        case (s1_cmd_reg)
            adc_scan_pkg::CMD_CONV_DONE:
            begin
                if (!scan_mode_reg)
                begin
                    latest_next      = s1_sample_reg;
                    ready_next       = 1'b1;
                    cur_channel_next = single_channel_reg;
                end
                else if (channel_mask_reg != '0)
                begin
                    store_we          = 1'b1;
                    written_slot_next = adc_scan_pkg::SLOT_BITS'(prev_ch);
                    cur_channel_next  = next_ch;
                end
            end
            adc_scan_pkg::CMD_READ_SLOT:
            begin
                read_value_next = store_reg[s1_rch_reg];
            end
            adc_scan_pkg::CMD_RESTART:
            begin
                if (!scan_mode_reg)
                begin
                    cur_channel_next = single_channel_reg;
                end
                else if (channel_mask_reg != '0)
                begin
                    cur_channel_next = lowest_set(channel_mask_reg);
                end
            end
            adc_scan_pkg::CMD_READ_LATEST:
            begin
                read_value_next = latest_reg;
                ready_next      = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_channel_reg <= '0;
            latest_reg      <= '0;
            ready_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            mux_channel_reg <= '0;
        end
        else
        begin
            if (out_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_fire)
            begin
                cur_channel_reg <= cur_channel_next;
                latest_reg      <= latest_next;
                ready_reg       <= ready_next;
                mux_channel_reg <= cur_channel_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            written_slot_reg <= written_slot_next;
            read_value_reg   <= read_value_next;
        end
    end

    // Slot store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < adc_scan_pkg::NUM_CHANNELS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (s1_fire && store_we)
        begin
            store_reg[store_waddr] <= s1_sample_reg;
        end
    end

    // Checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("in_stall with empty input register");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (written_slot_reg == adc_scan_pkg::NO_SLOT
            || written_slot_reg < adc_scan_pkg::SLOT_BITS'(adc_scan_pkg::NUM_CHANNELS)))
        else $error("written_slot out of range");

    a_scan_conv_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_cmd_reg == adc_scan_pkg::CMD_CONV_DONE && scan_mode_reg
         && channel_mask_reg != '0)
        |=> (written_slot_reg != adc_scan_pkg::NO_SLOT && out_valid_reg))
        else $error("scan conversion did not write a slot");

    a_read_latest_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_cmd_reg == adc_scan_pkg::CMD_READ_LATEST) |=> !ready_reg)
        else $error("ready flag not cleared by read latest");

    a_single_conv_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_cmd_reg == adc_scan_pkg::CMD_CONV_DONE && !scan_mode_reg)
        |=> (ready_reg && written_slot_reg == adc_scan_pkg::NO_SLOT))
        else $error("single-mode conversion handled wrong");

endmodule

`default_nettype wire
